[rtl/core/dual_wheel_pid_pwm_drive_core_defines.svh]
// assertion macros shared by the drive core rtl
`ifndef DUAL_WHEEL_PID_PWM_DRIVE_CORE_DEFINES_SVH
`define DUAL_WHEEL_PID_PWM_DRIVE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DWPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DWPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dwpd_pkg.sv]
// shared types and constants of the dual wheel pid pwm drive core
package dwpd_pkg;

    // pipeline depth of one wheel lane
    localparam int NSTG = 7;

    // fixed field widths
    localparam int GAIN_WIDTH  = 8;
    localparam int DUTY_WIDTH  = 8;
    localparam int INTEG_WIDTH = 32;
    localparam int CFG_ADDR_WIDTH = 2;

    // divide by 10000: floor(x / 10000) == (x * DIV_MAGIC) >> DIV_SHIFT for x < 2**32
    localparam logic [63:0] DIV_MAGIC = 64'd3518437209;
    localparam int DIV_SHIFT = 45;
    localparam logic [31:0] INTEG_SCALE = 32'd10000;
    localparam logic signed [INTEG_WIDTH-1:0] INTEG_PRELOAD = 32'sd50000;

    // widths of the split integral term
    localparam int Q1_WIDTH   = 18;  // |acc| / 10000
    localparam int REM_WIDTH  = 14;  // |acc| % 10000
    localparam int KIQ_WIDTH  = 26;  // ki * (|acc| / 10000)
    localparam int KR_WIDTH   = 22;  // ki * (|acc| % 10000)
    localparam int Q2_WIDTH   = 8;   // ki * (|acc| % 10000) / 10000
    localparam int QMAG_WIDTH = 27;  // |trunc(ki * acc / 10000)|

    // register reset values
    localparam logic [GAIN_WIDTH-1:0] PROP_GAIN_RST  = 8'd10;
    localparam logic [GAIN_WIDTH-1:0] INTEG_GAIN_RST = 8'd40;
    localparam logic [GAIN_WIDTH-1:0] DERIV_GAIN_RST = 8'd1;
    localparam logic [DUTY_WIDTH-1:0] MAX_DUTY_RST   = 8'd150;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INTEG_GAIN = 2'd1,
        REG_DERIV_GAIN = 2'd2,
        REG_MAX_DUTY   = 2'd3
    } cfg_reg_t;

    // gains and clamp seen by both lanes
    typedef struct packed {
        logic [GAIN_WIDTH-1:0] prop_gain;
        logic [GAIN_WIDTH-1:0] integ_gain;
        logic [GAIN_WIDTH-1:0] deriv_gain;
        logic [DUTY_WIDTH-1:0] max_duty;
    } gain_cfg_t;

    // per-stage load strobes, load[0] is word acceptance
    typedef struct packed {
        logic [NSTG-1:0] load;
    } pipe_ctrl_t;

    // pwm pair of one wheel
    typedef struct packed {
        logic [DUTY_WIDTH-1:0] backward;
        logic [DUTY_WIDTH-1:0] forward;
    } wheel_duty_t;

endpackage

[rtl/core/dwpd_lane.sv]
// one wheel lane: pid error terms, integral state, split divide and duty select
module dwpd_lane #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dwpd_pkg::pipe_ctrl_t           ctrl,
    input  dwpd_pkg::gain_cfg_t            gains,
    input  logic signed [SPEED_WIDTH-1:0]  reference,
    input  logic signed [SPEED_WIDTH-1:0]  measured,
    output dwpd_pkg::wheel_duty_t          duty
);
    import dwpd_pkg::*;

    localparam int EW  = SPEED_WIDTH + 1;       // error
    localparam int DFW = SPEED_WIDTH + 2;       // error difference
    localparam int KPW = EW + GAIN_WIDTH + 1;   // kp * e
    localparam int KDW = DFW + GAIN_WIDTH + 1;  // kd * d
    localparam int PSW = KDW + 1;               // kp * e + kd * d
    localparam int DW  = ((PSW > QMAG_WIDTH + 1) ? PSW : QMAG_WIDTH + 1) + 1;

    // stage 1 is the state itself: acc_reg and last_reg hold the current word
    logic signed [INTEG_WIDTH-1:0] acc_reg;
    logic signed [EW-1:0]          last_reg;
    logic signed [DFW-1:0]         d1_reg;
    logic                          refz1_reg;

    logic signed [EW-1:0]          e_c;
    logic signed [INTEG_WIDTH:0]   asum_c;
    logic signed [INTEG_WIDTH-1:0] asat_c;
    logic signed [DFW-1:0]         d_c;

    // error, saturating integral, difference
    always_comb
    begin
        e_c    = {reference[SPEED_WIDTH-1], reference} - {measured[SPEED_WIDTH-1], measured};
        asum_c = {acc_reg[INTEG_WIDTH-1], acc_reg}
                 + {{(INTEG_WIDTH+1-EW){e_c[EW-1]}}, e_c};
        if (asum_c[INTEG_WIDTH] != asum_c[INTEG_WIDTH-1])
        begin
            asat_c = asum_c[INTEG_WIDTH] ? {1'b1, {(INTEG_WIDTH-1){1'b0}}}
                                          : {1'b0, {(INTEG_WIDTH-1){1'b1}}};
        end
        else
        begin
            asat_c = asum_c[INTEG_WIDTH-1:0];
        end
        d_c = {e_c[EW-1], e_c} - {last_reg[EW-1], last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= INTEG_PRELOAD;
            last_reg <= '0;
        end
        else if (ctrl.load[0])
        begin
            acc_reg  <= asat_c;
            last_reg <= e_c;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            d1_reg    <= d_c;
            refz1_reg <= (reference == '0);
        end
    end

    // stage 2: |acc| / 10000 by reciprocal, kp and kd products
    logic [INTEG_WIDTH-1:0] maga_c;
    logic [63:0]            p1_c;
    logic [Q1_WIDTH-1:0]    q1_2_reg;
    logic [INTEG_WIDTH-1:0] maga2_reg;
    logic                   aneg2_reg;
    logic signed [KPW-1:0]  kpe2_reg;
    logic signed [KDW-1:0]  kdd2_reg;
    logic                   refz2_reg;

    assign maga_c = acc_reg[INTEG_WIDTH-1] ? INTEG_WIDTH'(-acc_reg) : INTEG_WIDTH'(acc_reg);
    assign p1_c   = {{(64-INTEG_WIDTH){1'b0}}, maga_c} * DIV_MAGIC;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            q1_2_reg  <= p1_c[DIV_SHIFT +: Q1_WIDTH];
            maga2_reg <= maga_c;
            aneg2_reg <= acc_reg[INTEG_WIDTH-1];
            kpe2_reg  <= last_reg * $signed({1'b0, gains.prop_gain});
            kdd2_reg  <= d1_reg * $signed({1'b0, gains.deriv_gain});
            refz2_reg <= refz1_reg;
        end
    end

    // stage 3: remainder, ki times quotient, pd sum
    logic [INTEG_WIDTH-1:0] rem_full_c;
    logic [KIQ_WIDTH-1:0]   kiq_c;
    logic [REM_WIDTH-1:0]   rem3_reg;
    logic [KIQ_WIDTH-1:0]   kiq3_reg;
    logic                   aneg3_reg;
    logic signed [PSW-1:0]  psum3_reg;
    logic                   refz3_reg;

    assign rem_full_c = maga2_reg
                        - ({{(INTEG_WIDTH-Q1_WIDTH){1'b0}}, q1_2_reg} * INTEG_SCALE);
    assign kiq_c = {{(KIQ_WIDTH-GAIN_WIDTH){1'b0}}, gains.integ_gain}
                   * {{(KIQ_WIDTH-Q1_WIDTH){1'b0}}, q1_2_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            rem3_reg  <= rem_full_c[REM_WIDTH-1:0];
            kiq3_reg  <= kiq_c;
            aneg3_reg <= aneg2_reg;
            psum3_reg <= {{(PSW-KPW){kpe2_reg[KPW-1]}}, kpe2_reg}
                         + {kdd2_reg[KDW-1], kdd2_reg};
            refz3_reg <= refz2_reg;
        end
    end

    // stage 4: ki times remainder
    logic [KR_WIDTH-1:0]   kr_c;
    logic [KR_WIDTH-1:0]   kr4_reg;
    logic [KIQ_WIDTH-1:0]  kiq4_reg;
    logic                  aneg4_reg;
    logic signed [PSW-1:0] psum4_reg;
    logic                  refz4_reg;

    assign kr_c = {{(KR_WIDTH-GAIN_WIDTH){1'b0}}, gains.integ_gain}
                  * {{(KR_WIDTH-REM_WIDTH){1'b0}}, rem3_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            kr4_reg   <= kr_c;
            kiq4_reg  <= kiq3_reg;
            aneg4_reg <= aneg3_reg;
            psum4_reg <= psum3_reg;
            refz4_reg <= refz3_reg;
        end
    end

    // stage 5: second reciprocal divide of the remainder product
    logic [63:0]           p2_c;
    logic [Q2_WIDTH-1:0]   q2_5_reg;
    logic [KR_WIDTH-1:0]   kr5_reg;
    logic [KIQ_WIDTH-1:0]  kiq5_reg;
    logic                  aneg5_reg;
    logic signed [PSW-1:0] psum5_reg;
    logic                  refz5_reg;

    assign p2_c = {{(64-KR_WIDTH){1'b0}}, kr4_reg} * DIV_MAGIC;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            q2_5_reg  <= p2_c[DIV_SHIFT +: Q2_WIDTH];
            kr5_reg   <= kr4_reg;
            kiq5_reg  <= kiq4_reg;
            aneg5_reg <= aneg4_reg;
            psum5_reg <= psum4_reg;
            refz5_reg <= refz4_reg;
        end
    end

    // stage 6: integral quotient magnitude and nonzero remainder flag
    logic [KR_WIDTH-1:0]   q2x_c;
    logic [QMAG_WIDTH-1:0] qmag6_reg;
    logic                  nz6_reg;
    logic                  aneg6_reg;
    logic signed [PSW-1:0] psum6_reg;
    logic                  refz6_reg;

    assign q2x_c = {{(KR_WIDTH-Q2_WIDTH){1'b0}}, q2_5_reg} * INTEG_SCALE[KR_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[5])
        begin
            qmag6_reg <= {{(QMAG_WIDTH-KIQ_WIDTH){1'b0}}, kiq5_reg}
                         + {{(QMAG_WIDTH-Q2_WIDTH){1'b0}}, q2_5_reg};
            nz6_reg   <= (kr5_reg != q2x_c);
            aneg6_reg <= aneg5_reg;
            psum6_reg <= psum5_reg;
            refz6_reg <= refz5_reg;
        end
    end

    // stage 7: drive = pd + integral quotient, fixed toward zero by the remainder sign
    logic [DW-1:0]        qext_c;
    logic signed [DW-1:0] qs_c;
    logic signed [DW-1:0] t_c;
    logic signed [DW-1:0] drive_c;
    logic signed [DW-1:0] drive7_reg;
    logic                 refz7_reg;

    always_comb
    begin
        qext_c = {{(DW-QMAG_WIDTH){1'b0}}, qmag6_reg};
        qs_c   = aneg6_reg ? -$signed(qext_c) : $signed(qext_c);
        t_c    = {{(DW-PSW){psum6_reg[PSW-1]}}, psum6_reg} + qs_c;
        drive_c = t_c;
        if (nz6_reg && aneg6_reg && (t_c > 0))
        begin
            drive_c = t_c - DW'(1);
        end
        else if (nz6_reg && !aneg6_reg && (t_c < 0))
        begin
            drive_c = t_c + DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[6])
        begin
            drive7_reg <= drive_c;
            refz7_reg  <= refz6_reg;
        end
    end

    // magnitude, clamp, zero duty for a zero reference, and side select
    logic                  neg_c;
    logic [DW-1:0]         mag_c;
    logic [DUTY_WIDTH-1:0] dmag_c;

    always_comb
    begin
        neg_c = drive7_reg[DW-1];
        mag_c = neg_c ? DW'(-drive7_reg) : DW'(drive7_reg);
        if (refz7_reg)
        begin
            dmag_c = '0;
        end
        else if (mag_c > {{(DW-DUTY_WIDTH){1'b0}}, gains.max_duty})
        begin
            dmag_c = gains.max_duty;
        end
        else
        begin
            dmag_c = mag_c[DUTY_WIDTH-1:0];
        end
        duty.forward  = neg_c ? '0 : dmag_c;
        duty.backward = neg_c ? dmag_c : '0;
    end

endmodule

[rtl/core/dwpd_merge.sv]
// output stage: joins both lanes into one result word behind a register
module dwpd_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  dwpd_pkg::wheel_duty_t left_duty,
    input  dwpd_pkg::wheel_duty_t right_duty,
    input  logic                  m_axis_tready,
    output logic                  m_axis_tvalid,
    // left_forward_duty, left_backward_duty, right_forward_duty, right_backward_duty
    output logic [31:0]           m_axis_tdata,
    output logic                  free
);
    import dwpd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] data_reg;

    // register takes a new word when empty or being drained
    assign free       = !valid_reg || m_axis_tready;
    assign valid_next = load || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // pack the two pwm pairs, left forward in the lowest byte
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {right_duty.backward, right_duty.forward,
                         left_duty.backward, left_duty.forward};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

[rtl/core/dual_wheel_pid_pwm_drive_core.sv]
// An accepted word passes the 7 lane stages, then the output register, to reach m_axis.
// Throughput: one word per cycle unless m_axis stalls; 7-stage lane pipeline, output register.
// The integral and last-error state of each wheel updates at the accept edge.
// Stalls on m_axis back up stage by stage; s_axis_tready drops only when every stage is full.
// Reset: integrals to 50000, last errors to 0, gains to 10/40/1, max duty 150, pipeline empty.
`include "dual_wheel_pid_pwm_drive_core_defines.svh"

module dual_wheel_pid_pwm_drive_core #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // left_reference, left_measured, right_reference, right_measured, zero pad
    input  logic [((4*SPEED_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // left_forward_duty, left_backward_duty, right_forward_duty, right_backward_duty
    output logic [31:0]                            m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [dwpd_pkg::CFG_ADDR_WIDTH-1:0]    cfg_addr,
    input  logic [dwpd_pkg::GAIN_WIDTH-1:0]        cfg_wdata
);
    import dwpd_pkg::*;

    // configuration registers
    gain_cfg_t gains_reg;
    gain_cfg_t gains_next;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PROP_GAIN:  gains_next.prop_gain  = cfg_wdata;
                REG_INTEG_GAIN: gains_next.integ_gain = cfg_wdata;
                REG_DERIV_GAIN: gains_next.deriv_gain = cfg_wdata;
                REG_MAX_DUTY:   gains_next.max_duty   = cfg_wdata;
                default:        gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.prop_gain  <= PROP_GAIN_RST;
            gains_reg.integ_gain <= INTEG_GAIN_RST;
            gains_reg.deriv_gain <= DERIV_GAIN_RST;
            gains_reg.max_duty   <= MAX_DUTY_RST;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    // stage occupancy and load strobes, stalls ripple back from the output register
    logic [NSTG-1:0] pipe_v_reg;
    logic [NSTG-1:0] pipe_v_next;
    logic [NSTG-1:0] free;
    logic            out_free;
    logic            out_load;
    pipe_ctrl_t      ctrl;

    always_comb
    begin
        free[NSTG-1] = !pipe_v_reg[NSTG-1] || out_free;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            free[k] = !pipe_v_reg[k] || free[k+1];
        end
        ctrl.load[0] = s_axis_tvalid && free[0];
        for (int k = 1; k < NSTG; k++)
        begin
            ctrl.load[k] = pipe_v_reg[k-1] && free[k];
        end
        for (int k = 0; k < NSTG; k++)
        begin
            pipe_v_next[k] = ctrl.load[k] || (pipe_v_reg[k] && !free[k]);
        end
    end

    assign out_load      = pipe_v_reg[NSTG-1] && out_free;
    assign s_axis_tready = free[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_v_reg <= '0;
        end
        else
        begin
            pipe_v_reg <= pipe_v_next;
        end
    end

    // one lane per wheel
    wheel_duty_t left_duty;
    wheel_duty_t right_duty;

    dwpd_lane #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_left_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .gains     (gains_reg),
        .reference (s_axis_tdata[SPEED_WIDTH-1:0]),
        .measured  (s_axis_tdata[2*SPEED_WIDTH-1:SPEED_WIDTH]),
        .duty      (left_duty)
    );

    dwpd_lane #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_right_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .gains     (gains_reg),
        .reference (s_axis_tdata[3*SPEED_WIDTH-1:2*SPEED_WIDTH]),
        .measured  (s_axis_tdata[4*SPEED_WIDTH-1:3*SPEED_WIDTH]),
        .duty      (right_duty)
    );

    // result register joining both lanes
    dwpd_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (out_load),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .free          (out_free)
    );

    // checks on pipeline control and result words
    `DWPD_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid && s_axis_tready, pipe_v_reg[0], "accepted word missing from first stage")
    `DWPD_ASSERT_SAME(a_full_stall_blocks, (&pipe_v_reg) && m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while pipeline full and stalled")
    `DWPD_ASSERT_NEXT(a_last_stage_drains, pipe_v_reg[NSTG-1] && (!m_axis_tvalid || m_axis_tready), m_axis_tvalid, "finished word did not reach output")
    `DWPD_ASSERT_SAME(a_left_one_side, m_axis_tvalid, m_axis_tdata[7:0] == '0 || m_axis_tdata[15:8] == '0, "left pwm pair drives both sides")
    `DWPD_ASSERT_SAME(a_right_one_side, m_axis_tvalid, m_axis_tdata[23:16] == '0 || m_axis_tdata[31:24] == '0, "right pwm pair drives both sides")

endmodule
